// File: sv/bit_addressable_append_buffer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bit addressable append buffer
// Clocked on clk, quiet while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BIT_ADDRESSABLE_APPEND_BUFFER_DEFINES_SVH
`define BIT_ADDRESSABLE_APPEND_BUFFER_DEFINES_SVH

// same-cycle implication
`define BAB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bab assertion failed");

// next-cycle implication
`define BAB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bab assertion failed");

`endif

// File: sv/bab_pkg.sv
// ---------------------------------------------------------------------------
// bab_pkg
// Types and constants shared by the bit addressable append buffer.
// ---------------------------------------------------------------------------
package bab_pkg;

	typedef enum logic [2:0] {
		CMD_APPEND_BIT  = 3'd0,
		CMD_APPEND_BYTE = 3'd1,
		CMD_SET_BIT     = 3'd2,
		CMD_SET_BYTE    = 3'd3,
		CMD_GET_BIT     = 3'd4,
		CMD_GET_BYTE    = 3'd5,
		CMD_CLEAR       = 3'd6
	} cmd_t;

	localparam logic CFG_IDX_LIMIT_ON = 1'b0;
	localparam logic CFG_IDX_CAPACITY = 1'b1;

	localparam logic [11:0] CAPACITY_RESET = 12'd2048;

	// 16-bit window over two adjacent store bytes, MSB first
	localparam logic [15:0] WIN_BYTE_MASK = 16'hFF00;
	localparam logic [15:0] WIN_BIT_MASK  = 16'h8000;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE = 3'd0,
		BK_RD0  = 3'd1,
		BK_WR0  = 3'd2,
		BK_RD1  = 3'd3,
		BK_WR1  = 3'd4,
		BK_RESP = 3'd5
	} bk_state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [10:0] bit_position;
		logic        bit_value;
		logic [7:0]  byte_value;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [7:0]  read_data;
		logic [11:0] length_bits;
	} out_item_t;

	// classified command handed from front to back (store address travels beside it)
	typedef struct packed {
		op_kind_t    kind;
		logic        is_byte;
		logic        two_byte;
		logic [2:0]  offset;
		logic [15:0] wdata;
		logic [15:0] wmask;
		logic        ok;
		logic [11:0] length_bits;
	} op_ctrl_t;

endpackage

// File: sv/bit_addressable_append_buffer.sv
// ---------------------------------------------------------------------------
// bit_addressable_append_buffer
// Bit-granular append buffer over a byte store, MSB-first packing.
// ---------------------------------------------------------------------------
// Usage:
//   Commands arrive on in_valid/in_ready/in_data and each one produces exactly
//   one result on out_valid/out_ready/out_data, in order. A transfer happens
//   on a rising edge with valid and ready both high.
//   Configuration (limit enable, capacity in bits) is written through
//   cfg_we/cfg_index/cfg_wdata while no command is in flight.
//   The front checks length, capacity and range at acceptance and keeps the
//   bit length itself; a two-entry queue feeds the store sequencer.
//   Throughput is set by the single-port store sequencer, one command at a
//   time: clear and refused commands go straight to the result state, an
//   access within one store byte passes RD0 and WR0, and a byte that spans two store bytes also RD1 and WR1.
//   Reset clears the length to zero, the limit to off and capacity to 2048;
//   store contents are left undefined, with no clearing pass.
//   When the receiver stalls, the result holds in the output register, the
//   sequencer waits, and the queue takes up to two more commands.
// ---------------------------------------------------------------------------
module bit_addressable_append_buffer #(
	parameter int STORE_BYTES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bab_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bab_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [11:0]         cfg_wdata
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int QW = AW + $bits(bab_pkg::op_ctrl_t);

	// front to queue
	logic              push;
	logic [AW-1:0]     push_addr;
	bab_pkg::op_ctrl_t push_ctrl;
	logic              q_full;

	// queue to back
	logic [QW-1:0]     q_head;
	logic              q_empty;
	logic              pop;

	bab_front #(
		.STORE_BYTES (STORE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.push_addr (push_addr),
		.push_ctrl (push_ctrl)
	);

	// hold classified commands until the sequencer is free
	bab_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_addr, push_ctrl}),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	bab_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head_addr (q_head[QW-1 -: AW]),
		.head_ctrl (bab_pkg::op_ctrl_t'(q_head[QW-AW-1:0])),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: sv/bab_queue.sv
// ---------------------------------------------------------------------------
// bab_queue
// Two-entry queue between the command front and the store sequencer.
// ---------------------------------------------------------------------------
module bab_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/bab_front.sv
// ---------------------------------------------------------------------------
// bab_front
// Accepts commands, keeps the bit length and limits, and classifies each
// command into a store operation with its final status.
// ---------------------------------------------------------------------------
module bab_front #(
	parameter int STORE_BYTES = 256,
	localparam int AW = $clog2(STORE_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bab_pkg::in_item_t   in_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [11:0]         cfg_wdata,
	input  logic                q_full,
	output logic                push,
	output logic [AW-1:0]       push_addr,
	output bab_pkg::op_ctrl_t   push_ctrl
);

	localparam int STORE_BITS = STORE_BYTES * 8;
	localparam int LEN_W      = $clog2(STORE_BITS + 1);
	localparam int PW         = (LEN_W > 11) ? LEN_W : 11;
	localparam int CW         = ((PW > 12) ? PW : 12) + 1;

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_next;
	logic             limit_on_q;
	logic [11:0]      capacity_q;

	logic [CW-1:0] len_c, pos_c, cap_c, grow1_c, grow8_c;
	logic          fits1, fits8, bit_in_range, byte_in_range;
	logic [PW-1:0] where;
	logic          use_len;
	logic [2:0]    offset;
	logic [15:0]   byte_win, bit_win, byte_msk, bit_msk;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	assign len_c   = CW'(len_q);
	assign pos_c   = CW'(in_data.bit_position);
	assign cap_c   = CW'(capacity_q);
	assign grow1_c = len_c + CW'(1);
	assign grow8_c = len_c + CW'(8);

	assign fits1 = (grow1_c <= CW'(STORE_BITS)) && !(limit_on_q && (grow1_c > cap_c));
	assign fits8 = (grow8_c <= CW'(STORE_BITS)) && !(limit_on_q && (grow8_c > cap_c));
	assign bit_in_range  = pos_c < len_c;
	assign byte_in_range = (pos_c + CW'(8)) <= len_c;

	assign use_len = (in_data.cmd == bab_pkg::CMD_APPEND_BIT) ||
	                 (in_data.cmd == bab_pkg::CMD_APPEND_BYTE);
	assign where   = use_len ? PW'(len_q) : PW'(in_data.bit_position);
	assign offset  = where[2:0];
	assign push_addr = where[AW+2:3];

	assign byte_win = {in_data.byte_value, 8'h00} >> offset;
	assign bit_win  = {in_data.bit_value, 15'h0000} >> offset;
	assign byte_msk = bab_pkg::WIN_BYTE_MASK >> offset;
	assign bit_msk  = bab_pkg::WIN_BIT_MASK >> offset;

	always_comb begin
		push_ctrl.kind     = bab_pkg::OP_NONE;
		push_ctrl.is_byte  = 1'b0;
		push_ctrl.offset   = offset;
		push_ctrl.wdata    = bit_win;
		push_ctrl.wmask    = bit_msk;
		push_ctrl.ok       = 1'b0;
		len_next           = len_q;
		case (in_data.cmd)
			bab_pkg::CMD_APPEND_BIT: begin
				if (fits1) begin
					push_ctrl.kind = bab_pkg::OP_WRITE;
					push_ctrl.ok   = 1'b1;
					len_next       = grow1_c[LEN_W-1:0];
				end
			end
			bab_pkg::CMD_APPEND_BYTE: begin
				push_ctrl.is_byte = 1'b1;
				if (fits8) begin
					push_ctrl.kind = bab_pkg::OP_WRITE;
					push_ctrl.ok   = 1'b1;
					len_next       = grow8_c[LEN_W-1:0];
				end
			end
			bab_pkg::CMD_SET_BIT: begin
				if (bit_in_range) begin
					push_ctrl.kind = bab_pkg::OP_WRITE;
					push_ctrl.ok   = 1'b1;
				end
			end
			bab_pkg::CMD_SET_BYTE: begin
				push_ctrl.is_byte = 1'b1;
				if (byte_in_range) begin
					push_ctrl.kind = bab_pkg::OP_WRITE;
					push_ctrl.ok   = 1'b1;
				end
			end
			bab_pkg::CMD_GET_BIT: begin
				if (bit_in_range) begin
					push_ctrl.kind = bab_pkg::OP_READ;
					push_ctrl.ok   = 1'b1;
				end
			end
			bab_pkg::CMD_GET_BYTE: begin
				push_ctrl.is_byte = 1'b1;
				if (byte_in_range) begin
					push_ctrl.kind = bab_pkg::OP_READ;
					push_ctrl.ok   = 1'b1;
				end
			end
			bab_pkg::CMD_CLEAR: begin
				push_ctrl.ok = 1'b1;
				len_next     = '0;
			end
			default: begin
			end
		endcase
		if (push_ctrl.is_byte) begin
			push_ctrl.wdata = byte_win;
			push_ctrl.wmask = byte_msk;
		end
		push_ctrl.two_byte    = (push_ctrl.wmask[7:0] != 8'h00);
		push_ctrl.length_bits = 12'(len_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			limit_on_q <= 1'b0;
			capacity_q <= bab_pkg::CAPACITY_RESET;
		end else begin
			if (push) begin
				len_q <= len_next;
			end
			if (cfg_we) begin
				case (cfg_index)
					bab_pkg::CFG_IDX_LIMIT_ON: limit_on_q <= cfg_wdata[0];
					bab_pkg::CFG_IDX_CAPACITY: capacity_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: sv/bab_back.sv
// ---------------------------------------------------------------------------
// bab_back
// Store sequencer: read-modify-write, or just read, of one or two store
// bytes over a single-port memory, then the result into the output register.
// ---------------------------------------------------------------------------
module bab_back #(
	parameter int STORE_BYTES = 256,
	localparam int AW = $clog2(STORE_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  logic [AW-1:0]       head_addr,
	input  bab_pkg::op_ctrl_t   head_ctrl,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output bab_pkg::out_item_t  out_data
);

	logic [7:0] mem [STORE_BYTES];

	bab_pkg::bk_state_t state_q, state_next;
	bab_pkg::op_ctrl_t  op_q;
	logic [AW-1:0]      addr_q;
	logic [7:0]         rdata_q;
	logic [7:0]         rd_hi_q;
	logic [7:0]         rd_lo_q;
	bab_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic        mem_re, mem_we, out_load, is_write;
	logic [AW-1:0] mem_addr;
	logic [7:0]  mem_wdata;
	logic [15:0] window;
	bab_pkg::out_item_t result;

	assign is_write = (op_q.kind == bab_pkg::OP_WRITE);

	always_comb begin
		state_next = state_q;
		case (state_q)
			bab_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_next = (head_ctrl.kind == bab_pkg::OP_NONE) ?
					             bab_pkg::BK_RESP : bab_pkg::BK_RD0;
				end
			end
			bab_pkg::BK_RD0: state_next = bab_pkg::BK_WR0;
			bab_pkg::BK_WR0: state_next = op_q.two_byte ? bab_pkg::BK_RD1 : bab_pkg::BK_RESP;
			bab_pkg::BK_RD1: state_next = bab_pkg::BK_WR1;
			bab_pkg::BK_WR1: state_next = bab_pkg::BK_RESP;
			bab_pkg::BK_RESP: begin
				if (out_load) begin
					state_next = bab_pkg::BK_IDLE;
				end
			end
			default: state_next = bab_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = (rdata_q & ~op_q.wmask[15:8]) | (op_q.wdata[15:8] & op_q.wmask[15:8]);
		out_load  = 1'b0;
		case (state_q)
			bab_pkg::BK_IDLE: pop = !q_empty;
			bab_pkg::BK_RD0:  mem_re = 1'b1;
			bab_pkg::BK_WR0:  mem_we = is_write;
			bab_pkg::BK_RD1: begin
				mem_re   = 1'b1;
				mem_addr = addr_q + AW'(1);
			end
			bab_pkg::BK_WR1: begin
				mem_we    = is_write;
				mem_addr  = addr_q + AW'(1);
				mem_wdata = (rdata_q & ~op_q.wmask[7:0]) | (op_q.wdata[7:0] & op_q.wmask[7:0]);
			end
			bab_pkg::BK_RESP: out_load = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	// align the addressed bit or byte to the top of the window
	assign window = {rd_hi_q, rd_lo_q} << op_q.offset;

	always_comb begin
		result.ok          = op_q.ok;
		result.length_bits = op_q.length_bits;
		result.read_data   = 8'h00;
		if (op_q.kind == bab_pkg::OP_READ) begin
			result.read_data = op_q.is_byte ? window[15:8] : {7'h00, window[15]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= head_ctrl;
			addr_q <= head_addr;
		end
		if (state_q == bab_pkg::BK_WR0) begin
			rd_hi_q <= rdata_q;
		end
		if (state_q == bab_pkg::BK_WR1) begin
			rd_lo_q <= rdata_q;
		end
		if (out_load) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bab_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: sv/bab_checker.sv
// ---------------------------------------------------------------------------
// bab_checker
// Port-level checks on the result channel of the append buffer.
// ---------------------------------------------------------------------------
`include "bit_addressable_append_buffer_defines.svh"

module bab_checker #(
	parameter int STORE_BYTES = 256
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input bab_pkg::out_item_t out_data
);

	localparam logic [31:0] STORE_BITS = 32'(STORE_BYTES * 8);

	// refused commands never return data
	`BAB_ASSERT_NOW(a_refused_no_data, out_valid && !out_data.ok, out_data.read_data == 8'h00)

	// length never runs past the store
	`BAB_ASSERT_NOW(a_length_in_store, out_valid, 32'(out_data.length_bits) <= STORE_BITS)

	// a stalled result holds
	`BAB_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind bit_addressable_append_buffer bab_checker #(
	.STORE_BYTES (STORE_BYTES)
) u_bab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Bit addressable append buffer testbench
// Drives command transfers and checks every result against a bit-level mirror
// of the buffer. Covers empty and full buffers, unaligned byte appends,
// capacity refusals and range refusals. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD  = 20;
	localparam int          STORE_BYTES = 256;
	localparam int unsigned STORE_BITS  = STORE_BYTES * 8;
	localparam logic [2:0]  CMD_UNUSED  = 3'd7;
	localparam int          PRINT_LIMIT = 40;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	bab_pkg::in_item_t   in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	bab_pkg::out_item_t  out_data;
	logic                cfg_we    = 1'b0;
	logic                cfg_index = bab_pkg::CFG_IDX_LIMIT_ON;
	logic [11:0]         cfg_wdata = '0;

	// Commands waiting for the driver, and results owed by the block, oldest first.
	bab_pkg::in_item_t   pending_cmds[$];
	bab_pkg::out_item_t  answers_due[$];

	// Mirror of the buffer as the block should hold it.
	logic [7:0]  mirror_bytes [STORE_BYTES];
	int unsigned fill_bits;
	logic        limit_on;
	logic [11:0] cap_bits;

	// Length the stimulus expects while it plans a phase, and its ceiling.
	int unsigned plan_bits;
	int unsigned plan_limit;

	bit          no_idle;
	int unsigned send_gap;
	int unsigned stall_left;
	int          error_count;

	always #(CLK_PERIOD / 2) clk = ~clk;

	bit_addressable_append_buffer #(
		.STORE_BYTES(STORE_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// ------------------------------------------------------------------------
	// Buffer mirror
	// ------------------------------------------------------------------------

	// Bit p sits in byte p/8, most significant bit first.
	function automatic void write_bit(int unsigned p, logic v);
		mirror_bytes[(p >> 3) % STORE_BYTES][7 - (p & 7)] = v;
	endfunction

	function automatic logic read_bit(int unsigned p);
		return mirror_bytes[(p >> 3) % STORE_BYTES][7 - (p & 7)];
	endfunction

	function automatic void write_byte(int unsigned p, logic [7:0] b);
		for (int i = 0; i < 8; i++)
			write_bit(p + i, b[7 - i]);
	endfunction

	// The store always bounds the length; the capacity register only when enabled.
	function automatic bit room_for(int unsigned n);
		return n <= STORE_BITS && (!limit_on || n <= cap_bits);
	endfunction

	// Apply one command to the mirror and return the result the block owes.
	function automatic bab_pkg::out_item_t buffer_answer(bab_pkg::in_item_t c);
		bab_pkg::out_item_t r;
		int unsigned        p;
		logic [7:0]         gathered;
		r = '0;
		p = c.bit_position;
		gathered = '0;
		case (c.cmd)
			bab_pkg::CMD_APPEND_BIT: begin
				if (room_for(fill_bits + 1)) begin
					write_bit(fill_bits, c.bit_value);
					fill_bits += 1;
					r.ok = 1'b1;
				end
			end
			bab_pkg::CMD_APPEND_BYTE: begin
				if (room_for(fill_bits + 8)) begin
					write_byte(fill_bits, c.byte_value);
					fill_bits += 8;
					r.ok = 1'b1;
				end
			end
			bab_pkg::CMD_SET_BIT: begin
				if (p < fill_bits) begin
					write_bit(p, c.bit_value);
					r.ok = 1'b1;
				end
			end
			bab_pkg::CMD_SET_BYTE: begin
				if (p + 8 <= fill_bits) begin
					write_byte(p, c.byte_value);
					r.ok = 1'b1;
				end
			end
			bab_pkg::CMD_GET_BIT: begin
				if (p < fill_bits) begin
					r.read_data = {7'd0, read_bit(p)};
					r.ok = 1'b1;
				end
			end
			bab_pkg::CMD_GET_BYTE: begin
				if (p + 8 <= fill_bits) begin
					for (int i = 0; i < 8; i++)
						gathered = {gathered[6:0], read_bit(p + i)};
					r.read_data = gathered;
					r.ok = 1'b1;
				end
			end
			bab_pkg::CMD_CLEAR: begin
				// store contents stay; only the length goes
				fill_bits = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.length_bits = fill_bits[11:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Mostly back-to-back, sometimes short gaps, rarely long ones.
	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_command(logic [2:0] cmd, int unsigned pos,
			logic bitv, logic [7:0] bytev);
		bab_pkg::in_item_t c;
		c.cmd          = cmd;
		c.bit_position = 11'(pos);
		c.bit_value    = bitv;
		c.byte_value   = bytev;
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Draw one command. Most are appends or accesses that land inside the planned
	// length; the rest clear or probe the range edges, random positions and the unused code.
	function automatic bab_pkg::in_item_t random_command(bit may_clear);
		bab_pkg::in_item_t c;
		int unsigned       pick;
		int unsigned       edge_back;
		c.cmd          = bab_pkg::CMD_GET_BIT;
		c.bit_position = 11'($urandom);
		c.bit_value    = 1'($urandom);
		c.byte_value   = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			c.cmd = bab_pkg::CMD_APPEND_BIT;
			if (plan_bits + 1 <= plan_limit)
				plan_bits += 1;
		end else if (pick < 40) begin
			c.cmd = bab_pkg::CMD_APPEND_BYTE;
			if (plan_bits + 8 <= plan_limit)
				plan_bits += 8;
		end else if (pick < 86) begin
			case ($urandom_range(0, 3))
				0:       c.cmd = bab_pkg::CMD_SET_BIT;
				1:       c.cmd = bab_pkg::CMD_SET_BYTE;
				2:       c.cmd = bab_pkg::CMD_GET_BIT;
				default: c.cmd = bab_pkg::CMD_GET_BYTE;
			endcase
			if ((c.cmd == bab_pkg::CMD_SET_BYTE || c.cmd == bab_pkg::CMD_GET_BYTE)
					&& plan_bits >= 8)
				c.bit_position = 11'($urandom_range(0, plan_bits - 8));
			else if ((c.cmd == bab_pkg::CMD_SET_BIT || c.cmd == bab_pkg::CMD_GET_BIT)
					&& plan_bits > 0)
				c.bit_position = 11'($urandom_range(0, plan_bits - 1));
		end else if (pick < 97 || !may_clear) begin
			case ($urandom_range(0, 4))
				0:       c.cmd = bab_pkg::CMD_SET_BIT;
				1:       c.cmd = bab_pkg::CMD_SET_BYTE;
				2:       c.cmd = bab_pkg::CMD_GET_BIT;
				3:       c.cmd = bab_pkg::CMD_GET_BYTE;
				default: c.cmd = CMD_UNUSED;
			endcase
			// half of these sit right at the end of the length
			if ($urandom_range(0, 1) == 0) begin
				edge_back = $urandom_range(0, 8);
				c.bit_position = 11'(plan_bits > edge_back ? plan_bits - edge_back : 0);
			end
		end else begin
			c.cmd = bab_pkg::CMD_CLEAR;
			plan_bits = 0;
		end
		return c;
	endfunction

	task automatic queue_random(int count, bit may_clear);
		for (int i = 0; i < count; i++)
			pending_cmds.insert(pending_cmds.size(), random_command(may_clear));
	endtask

	task automatic write_register(logic idx, logic [11:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == bab_pkg::CFG_IDX_LIMIT_ON)
			limit_on = value[0];
		else
			cap_bits = value;
	endtask

	// Write both registers; only called with nothing in flight.
	task automatic configure(logic on, logic [11:0] cap);
		write_register(bab_pkg::CFG_IDX_LIMIT_ON, {11'd0, on});
		write_register(bab_pkg::CFG_IDX_CAPACITY, cap);
		plan_limit = (on && cap < STORE_BITS) ? cap : STORE_BITS;
	endtask

	// Wait until every queued command is transferred and every result is back.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || answers_due.size() != 0);
	endtask

	task automatic report_mismatch(string what);
		if (error_count < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// ------------------------------------------------------------------------
	// Driver: present the next pending command, hold it until the transfer.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap  = 0;
		end else begin
			// predict on the transfer, in transfer order
			if (in_valid && in_ready)
				answers_due.insert(answers_due.size(), buffer_answer(in_data));

			if (in_valid && !in_ready) begin
				// hold valid and payload until the block takes them
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				in_data  <= pending_cmds.pop_front();
				in_valid <= 1'b1;
				send_gap  = idle_length();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each result transfer, stall the output at random.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		bab_pkg::out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("result %p with no command pending", out_data));
				end else begin
					want = answers_due.pop_front();
					if (out_data.ok !== want.ok)
						report_mismatch($sformatf("ok %b, want %b",
							out_data.ok, want.ok));
					if (out_data.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %h, want %h",
							out_data.read_data, want.read_data));
					if (out_data.length_bits !== want.length_bits)
						report_mismatch($sformatf("length_bits %0d, want %0d",
							out_data.length_bits, want.length_bits));
				end
			end

			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = ($urandom_range(0, 3) == 0) ? idle_length() : 0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		fill_bits   = 0;
		limit_on    = 1'b0;
		cap_bits    = bab_pkg::CAPACITY_RESET;
		plan_bits   = 0;
		plan_limit  = STORE_BITS;
		no_idle     = 1'b0;
		error_count = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty-buffer refusals, unaligned appends, range edges.
		configure(1'b0, bab_pkg::CAPACITY_RESET);
		@(negedge clk);
		queue_command(bab_pkg::CMD_GET_BIT,     0,    1'b0, 8'h00);
		queue_command(bab_pkg::CMD_GET_BYTE,    0,    1'b0, 8'h00);
		queue_command(bab_pkg::CMD_SET_BIT,     0,    1'b1, 8'h00);
		queue_command(bab_pkg::CMD_SET_BYTE,    0,    1'b0, 8'hFF);
		queue_command(bab_pkg::CMD_APPEND_BIT,  0,    1'b1, 8'h00);
		queue_command(bab_pkg::CMD_APPEND_BIT,  0,    1'b0, 8'h00);
		// offset two: each byte spans two store bytes
		queue_command(bab_pkg::CMD_APPEND_BYTE, 0,    1'b0, 8'hFF);
		queue_command(bab_pkg::CMD_APPEND_BYTE, 0,    1'b0, 8'h00);
		queue_command(bab_pkg::CMD_APPEND_BYTE, 0,    1'b0, 8'hA5);
		queue_command(bab_pkg::CMD_GET_BIT,     0,    1'b0, 8'h00);
		queue_command(bab_pkg::CMD_GET_BYTE,    2,    1'b0, 8'h00);
		queue_command(bab_pkg::CMD_SET_BIT,     5,    1'b0, 8'h00);
		queue_command(bab_pkg::CMD_SET_BYTE,    3,    1'b0, 8'h5A);
		queue_command(bab_pkg::CMD_GET_BYTE,    3,    1'b0, 8'h00);
		// length is now 26: last full byte, one past it, last bit, one past it
		queue_command(bab_pkg::CMD_GET_BYTE,    18,   1'b0, 8'h00);
		queue_command(bab_pkg::CMD_GET_BYTE,    19,   1'b0, 8'h00);
		queue_command(bab_pkg::CMD_GET_BIT,     25,   1'b0, 8'h00);
		queue_command(bab_pkg::CMD_GET_BIT,     26,   1'b0, 8'h00);
		queue_command(bab_pkg::CMD_SET_BIT,     26,   1'b1, 8'h00);
		queue_command(bab_pkg::CMD_SET_BYTE,    2047, 1'b1, 8'hFF);
		queue_command(bab_pkg::CMD_GET_BIT,     2047, 1'b0, 8'h00);
		queue_command(CMD_UNUSED,               2047, 1'b1, 8'hFF);
		queue_command(bab_pkg::CMD_SET_BYTE,    8,    1'b0, 8'hFF);
		queue_command(bab_pkg::CMD_GET_BYTE,    8,    1'b0, 8'h00);
		queue_command(bab_pkg::CMD_CLEAR,       0,    1'b0, 8'h00);
		queue_command(bab_pkg::CMD_GET_BIT,     0,    1'b0, 8'h00);
		drain();
		plan_bits = 0;

		// Limit on with zero capacity: every append is refused. Run without idling.
		no_idle = 1'b1;
		configure(1'b1, 12'd0);
		queue_random(20, 1'b1);
		drain();

		// Small capacity: appends bump into the limit again and again.
		no_idle = 1'b0;
		configure(1'b1, 12'd37);
		queue_random(80, 1'b1);
		drain();

		// Limit off with zero capacity: the register must be ignored.
		no_idle = 1'b1;
		configure(1'b0, 12'd0);
		queue_random(80, 1'b1);
		drain();

		// Capacity above the store: fill the whole store, then hit its end.
		no_idle = 1'b0;
		configure(1'b1, 12'hFFF);
		queue_command(bab_pkg::CMD_CLEAR, 0, 1'b0, 8'h00);
		for (int i = 0; i < STORE_BYTES - 1; i++)
			queue_command(bab_pkg::CMD_APPEND_BYTE, 0, 1'b0, 8'($urandom));
		for (int i = 0; i < 8; i++)
			queue_command(bab_pkg::CMD_APPEND_BIT, 0, 1'($urandom), 8'h00);
		queue_command(bab_pkg::CMD_APPEND_BIT,  0,    1'b1, 8'h00);
		queue_command(bab_pkg::CMD_APPEND_BYTE, 0,    1'b0, 8'hFF);
		queue_command(bab_pkg::CMD_GET_BYTE,    2040, 1'b0, 8'h00);
		queue_command(bab_pkg::CMD_GET_BIT,     2047, 1'b0, 8'h00);
		queue_command(bab_pkg::CMD_SET_BIT,     2047, 1'b0, 8'h00);
		queue_command(bab_pkg::CMD_SET_BYTE,    2041, 1'b0, 8'h00);
		plan_bits = STORE_BITS;
		queue_random(45, 1'b0);
		drain();

		// Limit on at exactly the store size.
		configure(1'b1, bab_pkg::CAPACITY_RESET);
		queue_command(bab_pkg::CMD_CLEAR, 0, 1'b0, 8'h00);
		plan_bits = 0;
		queue_random(60, 1'b1);
		drain();

		// Random small capacity.
		configure(1'b1, 12'($urandom_range(1, 200)));
		queue_command(bab_pkg::CMD_CLEAR, 0, 1'b0, 8'h00);
		plan_bits = 0;
		queue_random(60, 1'b1);
		drain();

		// let any stray result show up before the verdict
		repeat (20) @(posedge clk);
		if (answers_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", answers_due.size()));
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/bab_pkg.sv
sv/bab_queue.sv
sv/bab_front.sv
sv/bab_back.sv
sv/bit_addressable_append_buffer.sv
sv/bab_checker.sv
bench/testbench.sv
